// ===== hw/rtl/fir_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fir_pkg
// Shared constants, types and the controller-to-datapath interface of the
// fixed-point FIR convolution core.
// ----------------------------------------------------------------------------
package fir_pkg;

  localparam int TAPS         = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int ACC_WIDTH    = 36;
  localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH;
  localparam int TAP_IDX_W    = $clog2(TAPS);
  localparam int TAP_CNT_W    = 5;

  // Stream payload widths, padded to whole bytes
  localparam int IN_DATA_W    = ((TAP_IDX_W + SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((ACC_WIDTH + 7) / 8) * 8;

  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = TAP_CNT_W'(10);

  // Item kinds carried on in_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } fir_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic                 load_coef;
    logic                 shift_sample;
    logic                 shift_zero;
    logic                 clear_window;
    logic                 clear_acc;
    logic                 mac_step;
    logic                 emit;
    logic                 emit_last;
    logic [TAP_IDX_W-1:0] tap_sel;
  } fir_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
  } fir_status_t;

endpackage : fir_pkg
`default_nettype wire

// ===== hw/rtl/fir_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fir_dp
// Datapath: coefficient store, sample window, one shared multiplier with a
// product register, the accumulator and the output register.
// ----------------------------------------------------------------------------
module fir_dp
  import fir_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire fir_cmd_t                       cmd,
  output fir_status_t                         status,
  input  wire logic        [TAP_IDX_W-1:0]    tap_index,
  input  wire logic signed [SAMPLE_WIDTH-1:0] value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed      [ACC_WIDTH-1:0]    out_sum,
  output logic                                out_last
);

  logic signed [SAMPLE_WIDTH-1:0] coef_r   [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] window_r [TAPS];
  logic signed [PROD_WIDTH-1:0]   prod_r;
  logic                           prod_vld_r;
  logic signed [ACC_WIDTH-1:0]    acc_r;
  logic signed [ACC_WIDTH-1:0]    acc_nxt;
  logic signed [ACC_WIDTH-1:0]    sum_r;
  logic                           last_r;
  logic                           valid_r;

  // Write one coefficient
  always_ff @(posedge clk) begin
    if (cmd.load_coef) begin
      coef_r[tap_index] <= value;
    end
  end

  // Shift the window; slot 0 holds the newest sample
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_window) begin
      for (int i = 0; i < TAPS; i++) begin
        window_r[i] <= '0;
      end
    end else if (cmd.shift_sample || cmd.shift_zero) begin
      for (int i = TAPS - 1; i > 0; i--) begin
        window_r[i] <= window_r[i-1];
      end
      window_r[0] <= cmd.shift_sample ? value : '0;
    end
  end

  // Multiply one tap per cycle into the product register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= cmd.mac_step;
    end
    prod_r <= coef_r[cmd.tap_sel] * window_r[cmd.tap_sel];
  end

  // Accumulate the previous product
  always_comb begin
    acc_nxt = acc_r;
    if (prod_vld_r) begin
      acc_nxt = acc_r + ACC_WIDTH'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_acc) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.emit) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sum_r  <= acc_r;
      last_r <= cmd.emit_last;
    end
  end

  assign status.out_free = !valid_r || out_ready;
  assign out_valid       = valid_r;
  assign out_sum         = sum_r;
  assign out_last        = last_r;

endmodule : fir_dp
`default_nettype wire

// ===== hw/rtl/fir_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fir_ctrl
// Controller: tap count register, tap walk counter, tail flush counter and
// the state machine that sequences the datapath.
// ----------------------------------------------------------------------------
module fir_ctrl
  import fir_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_op,
  input  wire logic                 in_final,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [TAP_CNT_W-1:0] cfg_data,
  input  wire fir_status_t          status,
  output fir_cmd_t                  cmd
);

  fir_state_t           state_r, state_nxt;
  logic [TAP_CNT_W-1:0] tap_count_r;
  logic [TAP_IDX_W-1:0] k_r, k_nxt;
  logic [TAP_IDX_W-1:0] rem_r, rem_nxt;
  logic                 final_r, final_nxt;
  logic [TAP_CNT_W-1:0] last_full;
  logic [TAP_IDX_W-1:0] last_k;
  logic                 accept;

  // Clamp the tap count to 1..TAPS, give the highest tap index used
  always_comb begin
    priority if (tap_count_r == '0) begin
      last_full = '0;
    end else if (tap_count_r > TAP_CNT_W'(TAPS)) begin
      last_full = TAP_CNT_W'(TAPS - 1);
    end else begin
      last_full = tap_count_r - TAP_CNT_W'(1);
    end
  end
  assign last_k = last_full[TAP_IDX_W-1:0];

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Tap count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RESET;
    end else if (cfg_valid) begin
      tap_count_r <= cfg_data;
    end
  end

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    rem_nxt   = rem_r;
    final_nxt = final_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_PUSH) begin
          state_nxt = ST_MAC;
          k_nxt     = '0;
          final_nxt = in_final;
          rem_nxt   = in_final ? last_k : '0;
        end
      end
      ST_MAC: begin
        k_nxt = k_r + TAP_IDX_W'(1);
        if (k_r == last_k) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          if (rem_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_MAC;
            k_nxt     = '0;
            rem_nxt   = rem_r - TAP_IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      rem_r   <= '0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      rem_r   <= rem_nxt;
      final_r <= final_nxt;
    end
  end

  // Datapath commands
  always_comb begin
    cmd         = '0;
    cmd.tap_sel = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_coef    = (in_op == OP_LOAD);
          cmd.shift_sample = (in_op == OP_PUSH);
          cmd.clear_acc    = (in_op == OP_PUSH);
        end
      end
      ST_MAC: begin
        cmd.mac_step = 1'b1;
      end
      ST_DRAIN: begin
        cmd.mac_step = 1'b0;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = (rem_r == '0);
          // Start the next tail output, or drop the window after the run
          if (rem_r != '0) begin
            cmd.shift_zero = 1'b1;
            cmd.clear_acc  = 1'b1;
          end else if (final_r) begin
            cmd.clear_window = 1'b1;
          end
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule : fir_ctrl
`default_nettype wire

// ===== hw/rtl/fixed_point_fir_convolution_core.sv =====
`default_nettype none
// A pushed sample walks n taps in the MAC state, adds the last product in the drain
// state, registers the sum in the emit state; n is the clamped tap count (1..16).
// The single shared multiplier walks one tap per cycle; no new item is taken until idle.
// A final sample adds n-1 tail outputs. A low out_tready holds the emit step while
// an earlier output is pending. A coefficient load is written on acceptance, leaving
// the core idle. rst_n (synchronous) clears window, control state, output valid; tap count 10.
// ----------------------------------------------------------------------------
// fixed_point_fir_convolution_core
// Direct-form FIR computing the full linear convolution of a signed sample
// stream with a loaded coefficient set, using one multiply-accumulate.
// ----------------------------------------------------------------------------
module fixed_point_fir_convolution_core
  import fir_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // tap_index[3:0], value[19:4], zero pad
  input  wire logic                  in_tuser,   // operation
  input  wire logic                  in_tlast,   // final_sample
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // sum[35:0], zero pad
  output logic                       out_tlast,  // end_of_run
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [TAP_CNT_W-1:0]  cfg_data    // tap_count
);

  fir_cmd_t                       cmd;
  fir_status_t                    status;
  logic [TAP_IDX_W-1:0]           tap_index;
  logic signed [SAMPLE_WIDTH-1:0] value;
  logic signed [ACC_WIDTH-1:0]    sum;

  // Unpack the input item
  assign tap_index = in_tdata[TAP_IDX_W-1:0];
  assign value     = in_tdata[TAP_IDX_W +: SAMPLE_WIDTH];

  fir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_final  (in_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  fir_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .tap_index (tap_index),
    .value     (value),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sum   (sum),
    .out_last  (out_tlast)
  );

  // Pack the result item
  assign out_tdata = OUT_DATA_W'(unsigned'(sum));

endmodule : fixed_point_fir_convolution_core
`default_nettype wire

// ===== tb/fixed_point_fir_convolution_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_fir_convolution_core_tb
// Self-checking testbench for the FIR convolution core. A queue-fed driver
// pushes coefficient loads and samples, a scoreboard predicts every output
// (including the tail flushed by a final sample), and a monitor compares each
// accepted output item against the oldest prediction. Tap count settings
// sweep the clamped extremes, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module fixed_point_fir_convolution_core_tb;
  import fir_pkg::*;

  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_GAP          = 16;
  localparam int RANDOM_PHASES    = 8;
  localparam int PHASE_ITEMS      = 9;
  localparam int HOLD_PHASE       = 2;

  localparam logic signed [SAMPLE_WIDTH-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_WIDTH-1:0] VAL_MAX = 16'sh7fff;

  typedef struct {
    logic                           op;
    logic [TAP_IDX_W-1:0]           tap_index;
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic                           fin;
  } fir_item_t;

  typedef struct {
    logic signed [ACC_WIDTH-1:0] sum;
    logic                        end_of_run;
  } fir_output_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;
  logic                   in_tuser   = OP_LOAD;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [TAP_CNT_W-1:0]   cfg_data   = '0;

  // Scoreboard state
  fir_item_t                      pending_items[$];
  fir_output_t                    expected_outputs[$];
  logic signed [SAMPLE_WIDTH-1:0] coef_bank [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] sample_window [TAPS];
  logic [TAP_CNT_W-1:0]           taps_setting = TAP_COUNT_RESET;
  int                             err_count    = 0;

  // Handshake bookkeeping between the edge processes
  int   in_accepted  = 0;
  int   out_accepted = 0;
  logic calm         = 1'b0;
  logic hold_req     = 1'b0;

  fixed_point_fir_convolution_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic int taps_in_use();
    if (taps_setting == 0) return 1;
    if (taps_setting > TAPS) return TAPS;
    return int'(taps_setting);
  endfunction

  // Shift one sample into the window and sum the products of the active taps
  function automatic logic signed [ACC_WIDTH-1:0] advance_window_sum(
      logic signed [SAMPLE_WIDTH-1:0] smp, int n);
    logic signed [ACC_WIDTH-1:0]    acc;
    logic signed [PROD_WIDTH-1:0]   prod;
    acc = '0;
    for (int k = TAPS - 1; k > 0; k--) sample_window[k] = sample_window[k-1];
    sample_window[0] = smp;
    for (int k = 0; k < n; k++) begin
      prod = coef_bank[k] * sample_window[k];
      acc  = acc + prod;
    end
    return acc;
  endfunction

  // Work out the outputs of one accepted item
  task automatic predict_fir_outputs(input fir_item_t it);
    int          n;
    fir_output_t res;
    if (it.op == OP_LOAD) begin
      coef_bank[it.tap_index] = it.value;
    end else begin
      n = taps_in_use();
      res.sum        = advance_window_sum(it.value, n);
      res.end_of_run = !it.fin || (n == 1);
      expected_outputs.push_back(res);
      if (it.fin) begin
        for (int i = 1; i < n; i++) begin
          res.sum        = advance_window_sum('0, n);
          res.end_of_run = (i == n - 1);
          expected_outputs.push_back(res);
        end
        for (int k = 0; k < TAPS; k++) sample_window[k] = '0;
      end
    end
  endtask

  task automatic add_item(input logic op, input logic [TAP_IDX_W-1:0] idx,
                          input logic signed [SAMPLE_WIDTH-1:0] val, input logic fin);
    fir_item_t it;
    it.op        = op;
    it.tap_index = idx;
    it.value     = val;
    it.fin       = fin;
    pending_items.push_back(it);
  endtask

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  // Mostly complete runs ending in a final sample, some loads and stray finals
  task automatic fill_random_phase(input int count);
    int added;
    int run_len;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) < 2) begin
        add_item(OP_LOAD, TAP_IDX_W'($urandom), rand_value(), 1'($urandom));
        added++;
      end else begin
        run_len = $urandom_range(1, 5);
        for (int j = 0; j < run_len; j++) begin
          add_item(OP_PUSH, TAP_IDX_W'($urandom), rand_value(),
                   ($urandom_range(0, 9) == 0) ? 1'($urandom) : (j == run_len - 1));
          added++;
        end
      end
    end
  endtask

  // Hold until all items are sent and all outputs are in, then let the core settle
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_outputs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tap_count(input logic [TAP_CNT_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk);
    while (!cfg_ready);
    taps_setting = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TAP_CNT_W-1:0] taps_for_phase(int p);
    case (p)
      0:       return TAP_CNT_W'(16);
      1:       return TAP_CNT_W'(0);
      2:       return TAP_CNT_W'(31);
      3:       return TAP_CNT_W'(1);
      4:       return TAP_CNT_W'(17);
      default: return TAP_CNT_W'($urandom);
    endcase
  endfunction

  // Input driver: hold an item until taken, then idle for the drawn gap
  always @(negedge clk) begin : in_driver
    static int seen = 0;
    static int gap  = 0;
    fir_item_t it;
    logic      taken;
    taken = (in_accepted != seen);
    seen  = in_accepted;
    if (!in_tvalid || taken) begin
      if (gap > 0) begin
        gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        it = pending_items.pop_front();
        in_tdata  <= IN_DATA_W'({it.value, it.tap_index});
        in_tuser  <= it.op;
        in_tlast  <= it.fin;
        in_tvalid <= 1'b1;
        gap = draw_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output receiver: stall for a drawn gap after each item, once for a long stretch on request
  always @(negedge clk) begin : out_receiver
    static int seen      = 0;
    static int wait_left = 0;
    static logic hold_done = 1'b0;
    if (out_accepted != seen) begin
      seen      = out_accepted;
      wait_left = draw_gap();
    end
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      wait_left = LONG_HOLD_CYCLES;
    end
    if (wait_left > 0) begin
      wait_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Predict from every item the core accepts
  always @(posedge clk) begin : in_monitor
    fir_item_t it;
    if (rst_n && in_tvalid && in_tready) begin
      it.op        = in_tuser;
      it.tap_index = in_tdata[TAP_IDX_W-1:0];
      it.value     = in_tdata[TAP_IDX_W +: SAMPLE_WIDTH];
      it.fin       = in_tlast;
      predict_fir_outputs(it);
      in_accepted <= in_accepted + 1;
    end
  end

  // Compare each accepted output item against the oldest prediction
  always @(posedge clk) begin : out_monitor
    fir_output_t                 want;
    logic signed [ACC_WIDTH-1:0] got_sum;
    if (rst_n && out_tvalid && out_tready) begin
      out_accepted <= out_accepted + 1;
      got_sum = out_tdata[ACC_WIDTH-1:0];
      if (expected_outputs.size() == 0) begin
        err_count++;
        $display("%0t: unexpected output, expected none, actual sum %0d last %0b",
                 $time, got_sum, out_tlast);
      end else begin
        want = expected_outputs.pop_front();
        if (got_sum !== want.sum) begin
          err_count++;
          $display("%0t: sum mismatch, expected %0d, actual %0d",
                   $time, want.sum, got_sum);
        end
        if (out_tlast !== want.end_of_run) begin
          err_count++;
          $display("%0t: end_of_run mismatch, expected %0b, actual %0b",
                   $time, want.end_of_run, out_tlast);
        end
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    // Full taps at the most negative coefficient, extreme samples
    write_tap_count(TAP_CNT_W'(16));
    for (int i = 0; i < TAPS; i++) add_item(OP_LOAD, TAP_IDX_W'(i), VAL_MIN, 1'(i));
    add_item(OP_PUSH, TAP_IDX_W'($urandom), VAL_MIN, 1'b0);
    add_item(OP_PUSH, TAP_IDX_W'($urandom), VAL_MIN, 1'b0);
    add_item(OP_PUSH, TAP_IDX_W'($urandom), VAL_MAX, 1'b1);
    wait_drained();

    // Single tap: final sample gives one output only
    write_tap_count(TAP_CNT_W'(1));
    add_item(OP_PUSH, TAP_IDX_W'($urandom), 16'sd12345, 1'b1);
    add_item(OP_PUSH, TAP_IDX_W'($urandom), -16'sd1, 1'b0);
    add_item(OP_LOAD, TAP_IDX_W'(0), VAL_MAX, 1'b0);
    add_item(OP_LOAD, TAP_IDX_W'(15), 16'sd1, 1'b1);
    add_item(OP_LOAD, TAP_IDX_W'(7), 16'sd0, 1'b0);
    add_item(OP_PUSH, TAP_IDX_W'($urandom), VAL_MIN, 1'b1);
    wait_drained();

    // Zero tap count acts as one tap
    write_tap_count(TAP_CNT_W'(0));
    add_item(OP_PUSH, TAP_IDX_W'($urandom), VAL_MAX, 1'b1);
    wait_drained();

    // Tap count above the tap store saturates
    write_tap_count(TAP_CNT_W'(31));
    add_item(OP_PUSH, TAP_IDX_W'($urandom), VAL_MIN, 1'b0);
    add_item(OP_PUSH, TAP_IDX_W'($urandom), 16'sd100, 1'b1);
    wait_drained();

    // Random phases, each with its own tap count
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_tap_count(taps_for_phase(p));
      calm = (p == HOLD_PHASE) || (p == HOLD_PHASE + 1);
      if (p == HOLD_PHASE) hold_req = 1'b1;
      fill_random_phase(PHASE_ITEMS);
      wait_drained();
    end

    if (expected_outputs.size() != 0) begin
      err_count++;
      $display("%0t: %0d outputs expected but never seen, actual none",
               $time, expected_outputs.size());
    end
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fir_pkg.sv
hw/rtl/fir_dp.sv
hw/rtl/fir_ctrl.sv
hw/rtl/fixed_point_fir_convolution_core.sv
tb/fixed_point_fir_convolution_core_tb.sv
